/* rtl/bgma_pkg.sv */
package bgma_pkg;

  // Window and field widths
  localparam int WindowLen = 60;
  localparam int AdcW      = 10;
  localparam int RegW      = 13;
  localparam int MvW       = 14;
  localparam int PctW      = 7;
  localparam int CntW      = $clog2(WindowLen + 1);
  localparam int PosW      = (WindowLen > 1) ? $clog2(WindowLen) : 1;
  localparam int SumW      = AdcW + CntW;

  // Shared divider: numerator covers avg*scale+500, two quotient bits per cycle
  localparam int DivNumW   = AdcW + RegW + 1;
  localparam int DivDenW   = RegW;
  localparam int DivSteps  = DivNumW / 2;
  localparam int DivCntW   = $clog2(DivSteps);
  localparam int PctNumW   = RegW + PctW;

  // Arithmetic constants
  localparam int RoundHalf   = 500;
  localparam int MvDivisor   = 1000;
  localparam int PercentFull = 100;

  // Register reset values
  localparam logic [RegW-1:0] ScaleReset = RegW'(4390);
  localparam logic [RegW-1:0] EmptyReset = RegW'(3300);
  localparam logic [RegW-1:0] FullReset  = RegW'(4200);

  // Configuration register indexes
  localparam int CfgIdxW = 2;
  typedef enum logic [CfgIdxW-1:0] {
    RegScale = 2'd0,
    RegEmpty = 2'd1,
    RegFull  = 2'd2
  } cfg_reg_e;

  // Sequencer states
  typedef enum logic [3:0] {
    StIdle,
    StRing,
    StAvgGo,
    StAvgWait,
    StMul,
    StMvGo,
    StMvWait,
    StPct,
    StPctGo,
    StPctWait,
    StFinish
  } gauge_state_e;

endpackage

/* rtl/bgma_div.sv */
module bgma_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [bgma_pkg::DivNumW-1:0] num_i,
  input  logic [bgma_pkg::DivDenW-1:0] den_i,
  output logic                         done_o,
  output logic [bgma_pkg::DivNumW-1:0] quo_o
);
  import bgma_pkg::*;

  localparam logic [DivCntW-1:0] CntLast = DivCntW'(DivSteps - 1);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [DivCntW-1:0] cnt_q, cnt_d;
  logic [DivDenW:0]   rem_q, rem_d;
  logic [DivNumW-1:0] quo_q, quo_d;
  logic [DivDenW-1:0] den_q, den_d;

  // Two restoring shift-subtract steps per cycle
  always_comb begin
    logic [DivDenW:0]   r;
    logic [DivNumW-1:0] q;
    r = rem_q;
    q = quo_q;
    for (int i = 0; i < 2; i++) begin
      r = {r[DivDenW-1:0], q[DivNumW-1]};
      q = {q[DivNumW-2:0], 1'b0};
      if (r >= {1'b0, den_q}) begin
        r    = r - {1'b0, den_q};
        q[0] = 1'b1;
      end
    end

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = num_i;
      den_d  = den_i;
    end else if (busy_q) begin
      rem_d = r;
      quo_d = q;
      cnt_d = cnt_q + DivCntW'(1);
      if (cnt_q == CntLast) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Hold operands
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

/* rtl/bgma_ring.sv */
module bgma_ring (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      upd_i,
  input  logic [bgma_pkg::AdcW-1:0] sample_i,
  output logic                      done_o,
  output logic [bgma_pkg::SumW-1:0] sum_o,
  output logic [bgma_pkg::CntW-1:0] fill_o
);
  import bgma_pkg::*;

  localparam logic [PosW-1:0] PosLast = PosW'(WindowLen - 1);
  localparam logic [CntW-1:0] FillMax = CntW'(WindowLen);

  logic [AdcW-1:0] ring_q [WindowLen];
  logic [AdcW-1:0] old_q;
  logic [AdcW-1:0] sample_q;
  logic            rd_q, wr_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic            full;

  assign full = (fill_q == FillMax);

  // Drop the oldest sample once the window is full, add the new one
  always_comb begin
    logic [SumW:0] acc;
    acc = {1'b0, sum_q} + (SumW+1)'(sample_q);
    if (full) begin
      acc = acc - (SumW+1)'(old_q);
    end
    sum_d  = acc[SumW-1:0];
    fill_d = full ? fill_q : fill_q + CntW'(1);
    pos_d  = (pos_q == PosLast) ? '0 : pos_q + PosW'(1);
  end

  // Sequence: read the slot, then write it and update the sum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q   <= 1'b0;
      wr_q   <= 1'b0;
      pos_q  <= '0;
      fill_q <= '0;
      sum_q  <= '0;
    end else begin
      rd_q <= upd_i;
      wr_q <= rd_q;
      if (wr_q) begin
        pos_q  <= pos_d;
        fill_q <= fill_d;
        sum_q  <= sum_d;
      end
    end
  end

  // Latch the sample of the accepted beat
  always_ff @(posedge clk_i) begin
    if (upd_i) begin
      sample_q <= sample_i;
    end
  end

  // Sample memory, registered read
  always_ff @(posedge clk_i) begin
    if (rd_q) begin
      old_q <= ring_q[pos_q];
    end
    if (wr_q) begin
      ring_q[pos_q] <= sample_q;
    end
  end

  assign done_o = wr_q;
  assign sum_o  = sum_q;
  assign fill_o = fill_q;

endmodule

/* rtl/battery_gauge_moving_average_core.sv */
// Battery gauge with a 60-sample moving average. Each adc_count beat is stored
// in a sample memory and folded into a running sum; the block returns the
// truncated mean, that mean scaled to millivolts (rounded), and a charge
// percentage clamped between the empty and full thresholds. One beat is
// worked at a time and in_ready_o stays low until its result is in the output
// register, most of a beat going to a shared two-bit-per-cycle divider that
// runs the mean, millivolt and percent divisions (the percent one is skipped
// when the reading is at or outside a threshold). A finished result waits in
// the output register while the next beat is accepted. Configuration registers
// must be written only with the block idle, which the block does not enforce.
module battery_gauge_moving_average_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [bgma_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [bgma_pkg::RegW-1:0]    cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [bgma_pkg::AdcW-1:0]    adc_count_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [bgma_pkg::AdcW-1:0]    average_count_o,
  output logic [bgma_pkg::MvW-1:0]     millivolts_o,
  output logic [bgma_pkg::PctW-1:0]    charge_percent_o
);
  import bgma_pkg::*;

  gauge_state_e state_q, state_d;

  logic [RegW-1:0] scale_q, empty_q, full_q;

  logic               ring_upd, ring_done;
  logic [SumW-1:0]    ring_sum;
  logic [CntW-1:0]    ring_fill;

  logic               div_start, div_done;
  logic [DivNumW-1:0] div_num, div_quo;
  logic [DivDenW-1:0] div_den;

  logic [AdcW-1:0]    avg_q;
  logic [DivNumW-1:0] prod_q;
  logic [MvW-1:0]     mv_q;
  logic [PctNumW-1:0] pnum_q;
  logic [PctW-1:0]    pct_q;

  logic               in_fire, out_free;
  logic               at_empty, at_full;
  logic [RegW-1:0]    mv_diff;

  logic               out_valid_q;
  logic [AdcW-1:0]    out_avg_q;
  logic [MvW-1:0]     out_mv_q;
  logic [PctW-1:0]    out_pct_q;

  assign in_fire  = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;
  assign at_empty = ({1'b0, mv_q} <= (MvW+1)'(empty_q));
  assign at_full  = ({1'b0, mv_q} >= (MvW+1)'(full_q));
  assign mv_diff  = mv_q[RegW-1:0] - empty_q;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= ScaleReset;
      empty_q <= EmptyReset;
      full_q  <= FullReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        RegScale: scale_q <= cfg_data_i;
        RegEmpty: empty_q <= cfg_data_i;
        RegFull:  full_q  <= cfg_data_i;
        default:  ;
      endcase
    end
  end

  // Sample memory and running sum
  bgma_ring u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (ring_upd),
    .sample_i (adc_count_i),
    .done_o   (ring_done),
    .sum_o    (ring_sum),
    .fill_o   (ring_fill)
  );

  // Shared divider
  bgma_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:    if (in_fire)   state_d = StRing;
      StRing:    if (ring_done) state_d = StAvgGo;
      StAvgGo:   state_d = StAvgWait;
      StAvgWait: if (div_done)  state_d = StMul;
      StMul:     state_d = StMvGo;
      StMvGo:    state_d = StMvWait;
      StMvWait:  if (div_done)  state_d = StPct;
      StPct: begin
        if (at_empty || at_full) begin
          state_d = StFinish;
        end else begin
          state_d = StPctGo;
        end
      end
      StPctGo:   state_d = StPctWait;
      StPctWait: if (div_done)  state_d = StFinish;
      StFinish:  if (out_free)  state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  // Sequencer outputs: handshake, ring update and divider operands
  always_comb begin
    in_ready_o = 1'b0;
    ring_upd   = 1'b0;
    div_start  = 1'b0;
    div_num    = '0;
    div_den    = '0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        ring_upd   = in_valid_i;
      end
      StAvgGo: begin
        div_start = 1'b1;
        div_num   = DivNumW'(ring_sum);
        div_den   = DivDenW'(ring_fill);
      end
      StMvGo: begin
        div_start = 1'b1;
        div_num   = prod_q;
        div_den   = DivDenW'(MvDivisor);
      end
      StPctGo: begin
        div_start = 1'b1;
        div_num   = DivNumW'(pnum_q);
        div_den   = full_q - empty_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath: capture quotients, scale and percent terms
  always_ff @(posedge clk_i) begin
    if (state_q == StAvgWait && div_done) begin
      avg_q <= div_quo[AdcW-1:0];
    end
    if (state_q == StMul) begin
      prod_q <= DivNumW'(avg_q) * DivNumW'(scale_q) + DivNumW'(RoundHalf);
    end
    if (state_q == StMvWait && div_done) begin
      mv_q <= div_quo[MvW-1:0];
    end
    if (state_q == StPct) begin
      pnum_q <= PctNumW'(mv_diff) * PctNumW'(PercentFull);
      if (at_empty) begin
        pct_q <= '0;
      end else if (at_full) begin
        pct_q <= PctW'(PercentFull);
      end
    end
    if (state_q == StPctWait && div_done) begin
      pct_q <= div_quo[PctW-1:0];
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == StFinish && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StFinish && out_free) begin
      out_avg_q <= avg_q;
      out_mv_q  <= mv_q;
      out_pct_q <= pct_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign average_count_o  = out_avg_q;
  assign millivolts_o     = out_mv_q;
  assign charge_percent_o = out_pct_q;

endmodule

/* sim/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bgma_pkg::*;

  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned SettleCycles = 64;
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned PhaseItems   = 78;
  localparam int unsigned MaxShown     = 10;
  localparam int unsigned AdcMax       = (1 << AdcW) - 1;
  localparam int unsigned RegMax       = (1 << RegW) - 1;
  // Index with no register behind it; writes to it must be ignored
  localparam logic [CfgIdxW-1:0] RegSpare = CfgIdxW'(3);

  typedef struct packed {
    logic [AdcW-1:0] average;
    logic [MvW-1:0]  mv;
    logic [PctW-1:0] pct;
  } gauge_reading_t;

  // Gauge predictor plus the queue of readings still owed by the block
  class gauge_board;
    logic [AdcW-1:0] ring [WindowLen];
    int unsigned     sum;
    int unsigned     wpos;
    int unsigned     fill;
    int unsigned     scale;
    int unsigned     empty_mv;
    int unsigned     full_mv;
    gauge_reading_t  owed [$];
    int unsigned     errors;

    function new();
      foreach (ring[i]) ring[i] = '0;
      sum      = 0;
      wpos     = 0;
      fill     = 0;
      scale    = ScaleReset;
      empty_mv = EmptyReset;
      full_mv  = FullReset;
      errors   = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [RegW-1:0] data);
      case (cfg_reg_e'(idx))
        RegScale: scale    = data;
        RegEmpty: empty_mv = data;
        RegFull:  full_mv  = data;
        default: ;
      endcase
    endfunction

    // Fold an accepted sample into the window and owe its reading
    function void note_sample(logic [AdcW-1:0] s);
      gauge_reading_t r;
      int unsigned    avg;
      int unsigned    mv;
      int unsigned    pct;
      if (fill >= WindowLen) sum -= ring[wpos];
      else fill++;
      ring[wpos] = s;
      sum += s;
      wpos = (wpos + 1 >= WindowLen) ? 0 : wpos + 1;
      avg = sum / fill;
      mv  = (avg * scale + RoundHalf) / MvDivisor;
      // The empty test wins when the thresholds are crossed
      if (mv <= empty_mv) pct = 0;
      else if (mv >= full_mv) pct = PercentFull;
      else pct = ((mv - empty_mv) * PercentFull) / (full_mv - empty_mv);
      r.average = avg[AdcW-1:0];
      r.mv      = mv[MvW-1:0];
      r.pct     = pct[PctW-1:0];
      owed.push_back(r);
    endfunction

    function void check_reading(gauge_reading_t got);
      gauge_reading_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= MaxShown)
          $display("%0t: reading with none owed: avg %0d mv %0d pct %0d",
                   $realtime, got.average, got.mv, got.pct);
        return;
      end
      want = owed.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MaxShown)
          $display("%0t: reading mismatch: avg %0d/%0d mv %0d/%0d pct %0d/%0d (exp/act)",
                   $realtime, want.average, got.average, want.mv, got.mv,
                   want.pct, got.pct);
      end
    endfunction

    function int unsigned pending();
      return owed.size();
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [RegW-1:0]     cfg_data_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [AdcW-1:0]     adc_count_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [AdcW-1:0]     average_count_o;
  logic [MvW-1:0]      millivolts_o;
  logic [PctW-1:0]     charge_percent_o;

  gauge_board  board = new();
  int unsigned burst_left = 0;
  bit          hold_req = 1'b0;

  battery_gauge_moving_average_core i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .adc_count_i      (adc_count_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .average_count_o  (average_count_o),
    .millivolts_o     (millivolts_o),
    .charge_percent_o (charge_percent_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("FAIL battery_gauge_moving_average_core");
        $finish;
      end
    end
  end

  // Check every accepted result beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      board.check_reading('{average_count_o, millivolts_o, charge_percent_o});
  end

  // Receiver: stretches of differing stall behavior, plus long hold-offs on request
  initial begin
    int unsigned mode;
    int unsigned len;
    int unsigned tick;
    out_ready_i = 1'b0;
    tick = 0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(10, 150);
      repeat (len) begin
        @(negedge clk_i);
        tick++;
        if (hold_req) begin
          hold_req    = 1'b0;
          out_ready_i = 1'b0;
          repeat (HoldCycles) @(negedge clk_i);
        end
        case (mode)
          0: out_ready_i = 1'b1;
          1: out_ready_i = $urandom_range(0, 1);
          2: out_ready_i = ($urandom_range(0, 4) == 0);
          default: out_ready_i = (tick % 3 == 0);
        endcase
      end
    end
  end

  // Offer one sample beat, with bursts and random gaps; return once accepted
  task automatic send_sample(input logic [AdcW-1:0] s);
    int unsigned gap;
    @(negedge clk_i);
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i  = 1'b1;
    adc_count_i = s;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_sample(s);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [RegW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.set_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Drop the input, wait for all owed readings, then let the block settle
  task automatic drain_and_settle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Mostly samples clustered around a level, some anywhere in range
  function automatic logic [AdcW-1:0] pick_sample(int center, int spread);
    int v;
    if ($urandom_range(0, 6) == 0) return AdcW'($urandom_range(0, AdcMax));
    v = center + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    if (v > int'(AdcMax)) v = AdcMax;
    return AdcW'(v);
  endfunction

  function automatic int clamp_reg(int v);
    if (v < 0) return 0;
    if (v > int'(RegMax)) return RegMax;
    return v;
  endfunction

  task automatic run_phase(input int unsigned scale, input int unsigned empty_mv,
                           input int unsigned full_mv, input int center,
                           input int spread, input bit spare, input bit hold);
    drain_and_settle();
    write_reg(RegScale, RegW'(scale));
    write_reg(RegEmpty, RegW'(empty_mv));
    write_reg(RegFull,  RegW'(full_mv));
    if (spare) write_reg(RegSpare, RegW'($urandom_range(0, RegMax)));
    // Stall the receiver while the samples keep coming
    if (hold) hold_req = 1'b1;
    repeat (PhaseItems) send_sample(pick_sample(center, spread));
  endtask

  // Random calibration with thresholds bracketing the level, sometimes crossed
  task automatic run_random_phase(input bit hold);
    int unsigned scale;
    int          center;
    int          mv_c;
    int          lo;
    int          hi;
    scale  = ($urandom_range(0, 5) == 0) ? RegMax : $urandom_range(0, RegMax);
    center = $urandom_range(0, AdcMax);
    mv_c   = (center * int'(scale) + RoundHalf) / MvDivisor;
    lo     = clamp_reg(mv_c - int'($urandom_range(0, 300)));
    hi     = clamp_reg(mv_c + int'($urandom_range(1, 300)));
    if ($urandom_range(0, 7) == 0)
      run_phase(scale, hi, lo, center, $urandom_range(0, 60), $urandom_range(0, 1), hold);
    else
      run_phase(scale, lo, hi, center, $urandom_range(0, 60), $urandom_range(0, 1), hold);
  endtask

  // Main sequence
  initial begin
    int unsigned directed [18];
    directed    = '{0, 1023, 1023, 0, 512, 1, 1022, 341, 682, 900,
                    800, 760, 770, 850, 950, 960, 1000, 1023};
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    adc_count_i = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed samples at reset calibration: extremes, ramps through the thresholds
    foreach (directed[i]) send_sample(AdcW'(directed[i]));

    // Reset calibration again, level between the thresholds
    run_phase(ScaleReset, EmptyReset, FullReset, 860, 40, 1'b0, 1'b0);
    // Register extremes
    run_phase(RegMax, 0, RegMax, $urandom_range(0, AdcMax), 60, 1'b0, 1'b1);
    run_phase(0, 0, 0, 512, 500, 1'b0, 1'b0);
    run_phase(1, 0, 0, 500, 30, 1'b1, 1'b0);
    // Crossed thresholds: equal, then empty above full, then both at the maximum
    run_phase(ScaleReset, 4000, 4000, 911, 20, 1'b0, 1'b0);
    run_phase(ScaleReset, 5000, 3000, 900, 150, 1'b1, 1'b0);
    run_phase(RegMax, RegMax, RegMax, 1000, 30, 1'b0, 1'b0);

    run_random_phase(1'b1);
    repeat (4) run_random_phase(1'b0);

    drain_and_settle();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS battery_gauge_moving_average_core");
    end else begin
      $display("FAIL battery_gauge_moving_average_core");
    end
    $finish;
  end

endmodule
